// File: rtl/bdta_pkg.sv
package bdta_pkg;

    // Buffer geometry
    localparam int BUFFER_SIZE = 256;
    localparam int FILL_LIMIT  = BUFFER_SIZE - 2;
    localparam int FILL_W      = ($clog2(BUFFER_SIZE) > 8) ? $clog2(BUFFER_SIZE) : 8;

    // Decimal conversion
    localparam int VAL_W        = 32;
    localparam int DIGITS       = 10;
    localparam int BCD_W        = 4 * DIGITS;
    localparam int SHIFT_W      = BCD_W + VAL_W;
    localparam int BITS_PER_CYC = 4;
    localparam int CONV_CYC     = VAL_W / BITS_PER_CYC;
    localparam int CONV_CNT_W   = $clog2(CONV_CYC);
    localparam int LEFT_W       = 4;

    // Command queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Characters
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_INT   = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0]        req_type;
        logic signed [31:0] value;
        logic [7:0]        char_in;
    } t_in;

    typedef struct packed {
        logic [7:0] character;
        logic [7:0] position;
        logic       last;
    } t_out;

    // Classified request handed from front to back
    typedef struct packed {
        t_req             kind;
        logic             neg;
        logic [BCD_W-1:0] bcd;
        logic [7:0]       ch;
    } t_cmd;

endpackage

// File: rtl/bdta_front.sv
module bdta_front
    import bdta_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_push,
    output t_cmd o_cmd,
    input  logic i_q_full
);

    typedef enum logic [2:0] {
        F_EMPTY = 3'b001,
        F_CONV  = 3'b010,
        F_FULL  = 3'b100
    } t_fstate;

    t_fstate               r_state, n_state;
    logic [CONV_CNT_W-1:0] r_cnt, n_cnt;
    logic [SHIFT_W-1:0]    r_sh, n_sh, w_stepped;
    t_cmd                  r_cmd, n_cmd;
    logic                  w_push, w_free, w_accept;
    logic [VAL_W-1:0]      w_raw, w_mag;

    // One double-dabble bit: adjust every BCD digit, then shift in the next binary bit
    function automatic logic [SHIFT_W-1:0] dabble_step(input logic [SHIFT_W-1:0] s);
        logic [SHIFT_W-1:0] t;
        t = s;
        for (int d = 0; d < DIGITS; d++) begin
            if (t[VAL_W + 4*d +: 4] >= 4'd5) begin
                t[VAL_W + 4*d +: 4] = t[VAL_W + 4*d +: 4] + 4'd3;
            end
        end
        return {t[SHIFT_W-2:0], 1'b0};
    endfunction

    // Handshake and conversion datapath
    always_comb begin
        w_push   = (r_state == F_FULL) && !i_q_full;
        w_free   = (r_state == F_EMPTY) || w_push;
        w_accept = i_in_valid && w_free;
        w_raw    = i_in_data.value;
        w_mag    = w_raw[VAL_W-1] ? (~w_raw + 1'b1) : w_raw;
        w_stepped = r_sh;
        for (int k = 0; k < BITS_PER_CYC; k++) begin
            w_stepped = dabble_step(w_stepped);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sh    = r_sh;
        n_cmd   = r_cmd;

        unique case (r_state)
            F_EMPTY: ;
            F_FULL: begin
                if (w_push) begin
                    n_state = F_EMPTY;
                end
            end
            F_CONV: begin
                n_sh  = w_stepped;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CONV_CNT_W'(CONV_CYC - 1)) begin
                    n_state   = F_FULL;
                    n_cmd.bcd = w_stepped[SHIFT_W-1 -: BCD_W];
                end
            end
            default: n_state = F_EMPTY;
        endcase

        // Classify a new transaction
        if (w_accept) begin
            n_cmd.kind = t_req'(i_in_data.req_type);
            n_cmd.neg  = w_raw[VAL_W-1];
            n_cmd.ch   = i_in_data.char_in;
            n_cmd.bcd  = '0;
            unique case (t_req'(i_in_data.req_type))
                REQ_CLEAR, REQ_BYTE: n_state = F_FULL;
                REQ_INT: begin
                    n_state = F_CONV;
                    n_cnt   = '0;
                    n_sh    = {{BCD_W{1'b0}}, w_mag};
                end
                REQ_NONE: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_EMPTY;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh  <= n_sh;
        r_cmd <= n_cmd;
    end

    assign o_in_stall = !w_free;
    assign o_push     = w_push;
    assign o_cmd      = r_cmd;

endmodule

// File: rtl/bdta_queue.sv
module bdta_queue
    import bdta_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_data
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push, w_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: rtl/bdta_back.sv
module bdta_back
    import bdta_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_q_cmd,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic              r_act, n_act;
    logic              r_ov, n_ov;
    t_out              r_out, n_out;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_isbyte, n_isbyte;
    logic [7:0]        r_byte, n_byte;
    logic              r_sign, n_sign;
    logic [BCD_W-1:0]  r_digits, n_digits;
    logic [LEFT_W-1:0] r_left, n_left;

    logic              w_out_free, w_step, w_full, w_last, w_finish, w_pop, w_emit;
    logic [7:0]        w_char;
    logic [LEFT_W-1:0] w_lz, w_ndig;
    logic              w_found;

    // Count leading zero digits of the queued value, keep at least one digit
    always_comb begin
        w_lz    = '0;
        w_found = 1'b0;
        for (int i = DIGITS - 1; i >= 0; i--) begin
            if (!w_found) begin
                if (i_q_cmd.bcd[4*i +: 4] == 4'd0) begin
                    w_lz = w_lz + 1'b1;
                end else begin
                    w_found = 1'b1;
                end
            end
        end
        if (w_lz == LEFT_W'(DIGITS)) begin
            w_lz = LEFT_W'(DIGITS - 1);
        end
        w_ndig = LEFT_W'(DIGITS) - w_lz;
    end

    // Sequencer control
    always_comb begin
        w_out_free = !r_ov || !i_out_stall;
        w_step     = r_act && w_out_free;
        w_full     = (r_fill >= FILL_W'(FILL_LIMIT));
        w_last     = (r_left == LEFT_W'(1)) || (r_fill == FILL_W'(FILL_LIMIT - 1));
        w_emit     = w_step && !w_full;
        w_finish   = w_step && (w_full || w_last);
        w_pop      = i_q_valid && (!r_act || w_finish);
        if (r_isbyte) begin
            w_char = r_byte;
        end else if (r_sign) begin
            w_char = CHAR_MINUS;
        end else begin
            w_char = CHAR_ZERO + {4'h0, r_digits[BCD_W-1 -: 4]};
        end
    end

    // Next state
    always_comb begin
        n_act    = r_act;
        n_ov     = r_ov;
        n_out    = r_out;
        n_fill   = r_fill;
        n_isbyte = r_isbyte;
        n_byte   = r_byte;
        n_sign   = r_sign;
        n_digits = r_digits;
        n_left   = r_left;

        if (w_out_free) begin
            n_ov = w_emit;
        end

        // Emit one character, or drop the rest of the run once the buffer is at its limit
        if (w_emit) begin
            n_out.character = w_char;
            n_out.position  = r_fill[7:0];
            n_out.last      = w_last;
            n_fill          = r_fill + 1'b1;
            n_left          = r_left - 1'b1;
            if (r_sign) begin
                n_sign = 1'b0;
            end else begin
                n_digits = {r_digits[BCD_W-5:0], 4'h0};
            end
        end
        if (w_finish) begin
            n_act = 1'b0;
        end

        // Load the next command
        if (w_pop) begin
            unique case (i_q_cmd.kind)
                REQ_CLEAR: begin
                    n_fill = '0;
                    n_act  = 1'b0;
                end
                REQ_BYTE: begin
                    n_act    = 1'b1;
                    n_isbyte = 1'b1;
                    n_byte   = i_q_cmd.ch;
                    n_sign   = 1'b0;
                    n_left   = LEFT_W'(1);
                end
                REQ_INT: begin
                    n_act    = 1'b1;
                    n_isbyte = 1'b0;
                    n_sign   = i_q_cmd.neg;
                    n_digits = BCD_W'(i_q_cmd.bcd << {w_lz, 2'b00});
                    n_left   = w_ndig + {{(LEFT_W-1){1'b0}}, i_q_cmd.neg};
                end
                default: n_act = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_ov   <= 1'b0;
            r_fill <= '0;
        end else begin
            r_act  <= n_act;
            r_ov   <= n_ov;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_isbyte <= n_isbyte;
        r_byte   <= n_byte;
        r_sign   <= n_sign;
        r_digits <= n_digits;
        r_left   <= n_left;
    end

    assign o_pop       = w_pop;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

// File: rtl/bounded_decimal_text_appender.sv
// Throughput: one output character per cycle while the output is not stalled. A byte transaction
// goes straight to the front's hand-off state; an integer first runs the double-dabble converter
// at 4 bits a cycle, overlapped with emission of earlier requests. Per request the slower of an
// integer's conversion and its n output characters sets the rate.
// A request reaches the output via the front's command register, the queue and the back's registers.
// Reset (synchronous, active low) clears the fill count, the command queue and all valids.
module bounded_decimal_text_appender
    import bdta_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic w_push, w_full, w_qv, w_pop;
    t_cmd w_cmd_in, w_cmd_out;

    // Accept and classify requests, convert integers to BCD
    bdta_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in),
        .i_q_full   (w_full)
    );

    // Decouple front and back
    bdta_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .o_full  (w_full),
        .o_valid (w_qv),
        .i_pop   (w_pop),
        .o_data  (w_cmd_out)
    );

    // Emit characters and track the fill count
    bdta_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_qv),
        .i_q_cmd     (w_cmd_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
